FILE: hdl/gtr_pkg.sv
// gtr_pkg: shared types, constants and the pixel address helper of the glyph text rasterizer
// depends on nothing; used by every module in hdl

package gtr_pkg;

    localparam int MAX_WIDTH     = 256;
    localparam int MAX_HEIGHT    = 64;
    localparam int FONT_BYTES    = 1024;
    localparam int GLYPH_ROWS    = 7;
    localparam int ROW_BYTES_MAX = (MAX_WIDTH + 7) / 8;
    localparam int FB_BYTES      = ROW_BYTES_MAX * MAX_HEIGHT;
    localparam int FB_AW         = $clog2(FB_BYTES);
    localparam int GL_AW         = $clog2(FONT_BYTES);
    localparam int ROW_W         = $clog2(GLYPH_ROWS);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int MAX_GLYPH_W   = 8;

    typedef enum logic [2:0] {
        REG_FB_WIDTH      = 3'd0,
        REG_FB_HEIGHT     = 3'd1,
        REG_FIRST_CODE    = 3'd2,
        REG_LAST_CODE     = 3'd3,
        REG_GLYPH_WIDTH   = 3'd4,
        REG_GLYPH_SPACING = 3'd5,
        REG_GLYPH_BYTES   = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_PIXEL  = 2'd0,
        OP_CHAR   = 2'd1,
        OP_GLOAD  = 2'd2,
        OP_FBREAD = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GREAD,
        ST_COLS
    } back_state_t;

    // configuration as the datapath sees it, display sizes and glyph width already saturated
    typedef struct packed {
        logic [8:0] width;
        logic [6:0] height;
        logic [7:0] first_code;
        logic [7:0] last_code;
        logic [3:0] glyph_width;
        logic [2:0] glyph_spacing;
        logic [4:0] glyph_bytes;
    } cfg_t;

    typedef struct packed {
        logic             hit;
        logic [FB_AW-1:0] addr;
        logic [2:0]       bit_idx;
    } pix_t;

    typedef struct packed {
        op_t                op;
        pix_t               pix;
        logic               pixel_value;
        logic               start_text;
        logic [15:0]        pos_x;
        logic signed [15:0] pos_y;
        logic               char_ok;
        logic [12:0]        glyph_base;
        logic signed [15:0] clip_left;
        logic [11:0]        clip_span;
        logic [GL_AW-1:0]   glyph_addr;
        logic [7:0]         glyph_data;
        logic [FB_AW-1:0]   fb_addr;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

    // bounds check, mirrored x, byte address and msb-first bit of one pixel
    function automatic pix_t pixel_locate(logic signed [16:0] x, logic signed [16:0] y,
                                          logic [8:0] w, logic [6:0] h);
        pix_t       p;
        logic [8:0] mx;
        logic [9:0] wsum;
        logic [5:0] row_bytes;
        logic [11:0] row_off;
        p.hit     = (x >= 17'sd0) && (x < $signed({8'b0, w}))
                 && (y >= 17'sd0) && (y < $signed({10'b0, h}));
        mx        = w - 9'd1 - x[8:0];
        wsum      = {1'b0, w} + 10'd7;
        row_bytes = wsum[8:3];
        row_off   = y[5:0] * row_bytes;
        p.addr    = FB_AW'(row_off + {7'b0, mx[7:3]});
        p.bit_idx = mx[2:0];
        return p;
    endfunction

endpackage

FILE: hdl/gtr_front.sv
// gtr_front: takes items on the command port, classifies them and fills the command queue
// depends on gtr_pkg

module gtr_front (
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            kind,
    input  logic signed [15:0]    pos_x,
    input  logic signed [15:0]    pos_y,
    input  logic                  pixel_value,
    input  logic [7:0]            char_code,
    input  logic                  start_text,
    input  logic signed [15:0]    clip_left,
    input  logic [11:0]           clip_span,
    input  logic [9:0]            glyph_addr,
    input  logic [7:0]            glyph_data,
    input  logic [10:0]           fb_addr,
    input  gtr_pkg::cfg_t         cfg,
    input  logic                  clearing,
    input  gtr_pkg::qstat_t       qstat,
    output logic                  push,
    output gtr_pkg::cmd_t         cmd
);

    logic [7:0] code_off;

    assign busy     = clearing || qstat.full;
    assign push     = start && !busy;
    assign code_off = char_code - cfg.first_code;

    always_comb
    begin
        cmd.op          = gtr_pkg::op_t'(kind);
        cmd.pix         = gtr_pkg::pixel_locate({pos_x[15], pos_x}, {pos_y[15], pos_y},
                                                cfg.width, cfg.height);
        cmd.pixel_value = pixel_value;
        cmd.start_text  = start_text;
        cmd.pos_x       = pos_x;
        cmd.pos_y       = pos_y;
        // codes outside the font draw nothing and do not advance the cursor, though start_text still loads it
        cmd.char_ok     = (char_code >= cfg.first_code) && (char_code <= cfg.last_code);
        cmd.glyph_base  = cfg.glyph_bytes * code_off;
        cmd.clip_left   = clip_left;
        cmd.clip_span   = clip_span;
        cmd.glyph_addr  = glyph_addr;
        cmd.glyph_data  = glyph_data;
        cmd.fb_addr     = fb_addr;
    end

endmodule

FILE: hdl/gtr_cmd_queue.sv
// gtr_cmd_queue: short command fifo between the front and the back
// depends on gtr_pkg

module gtr_cmd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gtr_pkg::cmd_t   push_cmd,
    input  logic            pop,
    output gtr_pkg::cmd_t   head,
    output gtr_pkg::qstat_t qstat
);

    gtr_pkg::cmd_t                 entry_reg [gtr_pkg::QUEUE_DEPTH];
    logic [gtr_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [gtr_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [gtr_pkg::QPTR_W:0]      count_reg, count_next;

    assign head        = entry_reg[rd_ptr_reg];
    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == (gtr_pkg::QPTR_W + 1)'(gtr_pkg::QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == gtr_pkg::QPTR_W'(gtr_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == gtr_pkg::QPTR_W'(gtr_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hdl/gtr_back.sv
// gtr_back: executes queued commands on the framebuffer and glyph memories
// depends on gtr_pkg; holds both memories, the text cursor and the read-back port

module gtr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  gtr_pkg::cfg_t   cfg,
    input  gtr_pkg::cmd_t   head,
    input  gtr_pkg::qstat_t qstat,
    output logic            pop,
    output logic            clearing,
    output logic [7:0]      fb_byte,
    output logic            done
);

    gtr_pkg::back_state_t state_reg, state_next;

    logic [gtr_pkg::FB_AW-1:0] clr_cnt_reg;
    logic [15:0]               cursor_reg, cursor_next;
    logic [gtr_pkg::ROW_W-1:0] row_reg, row_next;
    logic [2:0]                col_reg, col_next;
    logic signed [15:0]        top_reg, top_next;
    logic signed [15:0]        clip_left_reg, clip_left_next;
    logic [11:0]               clip_span_reg, clip_span_next;
    logic [12:0]               base_reg, base_next;

    logic [7:0]                glyph_mem [gtr_pkg::FONT_BYTES];
    logic [7:0]                gl_rd_data_reg;
    logic                      gl_oob_reg;
    logic                      gl_we;
    logic [12:0]               gl_rd_addr;

    logic [7:0]                fb_mem [gtr_pkg::FB_BYTES];
    logic [7:0]                fb_rd_data_reg;
    logic                      fb_we;
    logic [gtr_pkg::FB_AW-1:0] fb_wa;
    logic [7:0]                fb_wd;

    // issue stage: at most one framebuffer access launched per cycle
    logic                      iss_valid;
    logic                      iss_read;
    logic [gtr_pkg::FB_AW-1:0] iss_addr;
    logic [2:0]                iss_bit;
    logic                      iss_value;

    // merge stage: read data back, modify, write
    logic                      s2_valid_reg;
    logic                      s2_read_reg;
    logic [gtr_pkg::FB_AW-1:0] s2_addr_reg;
    logic [2:0]                s2_bit_reg;
    logic                      s2_value_reg;
    logic                      lw_valid_reg;
    logic [gtr_pkg::FB_AW-1:0] lw_addr_reg;
    logic [7:0]                lw_data_reg;
    logic [7:0]                s2_old;
    logic [7:0]                s2_mask;
    logic [7:0]                s2_new;
    logic [7:0]                fb_byte_reg;
    logic                      done_reg;

    logic [15:0]               cur_sel;
    logic signed [16:0]        px, py, clip_l, clip_r;
    logic                      in_clip;
    logic [3:0]                shift;
    logic [7:0]                gbits;
    gtr_pkg::pix_t             pl;

    assign clearing   = (state_reg == gtr_pkg::ST_CLEAR);
    assign fb_byte    = fb_byte_reg;
    assign done       = done_reg;
    assign gl_rd_addr = base_reg + {10'b0, row_reg};

    // column geometry of the character being drawn
    assign px      = $signed({cursor_reg[15], cursor_reg}) + $signed({14'b0, col_reg});
    assign py      = $signed({top_reg[15], top_reg}) + $signed({14'b0, row_reg});
    assign clip_l  = $signed({clip_left_reg[15], clip_left_reg});
    assign clip_r  = clip_l + $signed({5'b0, clip_span_reg});
    assign in_clip = (clip_span_reg == '0) || ((px >= clip_l) && (px < clip_r));
    assign shift   = cfg.glyph_width - 4'd1 - {1'b0, col_reg};
    assign gbits   = gl_oob_reg ? 8'h00 : gl_rd_data_reg;
    assign pl      = gtr_pkg::pixel_locate(px, py, cfg.width, cfg.height);

    always_comb
    begin
        state_next     = state_reg;
        pop            = 1'b0;
        cursor_next    = cursor_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        top_next       = top_reg;
        clip_left_next = clip_left_reg;
        clip_span_next = clip_span_reg;
        base_next      = base_reg;
        gl_we          = 1'b0;
        iss_valid      = 1'b0;
        iss_read       = 1'b0;
        iss_addr       = head.pix.addr;
        iss_bit        = head.pix.bit_idx;
        iss_value      = head.pixel_value;
        cur_sel        = head.start_text ? head.pos_x : cursor_reg;
        unique case (state_reg)
            gtr_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == gtr_pkg::FB_AW'(gtr_pkg::FB_BYTES - 1))
                begin
                    state_next = gtr_pkg::ST_IDLE;
                end
            end
            gtr_pkg::ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop = 1'b1;
                    unique case (head.op)
                        gtr_pkg::OP_PIXEL:
                        begin
                            iss_valid = head.pix.hit;
                        end
                        gtr_pkg::OP_CHAR:
                        begin
                            cursor_next    = cur_sel;
                            top_next       = head.pos_y;
                            clip_left_next = head.clip_left;
                            clip_span_next = head.clip_span;
                            base_next      = head.glyph_base;
                            row_next       = '0;
                            if (head.char_ok)
                            begin
                                if (cfg.glyph_width == 4'd0)
                                begin
                                    // zero width draws nothing, spacing still advances
                                    cursor_next = cur_sel + 16'(cfg.glyph_spacing);
                                end
                                else
                                begin
                                    state_next = gtr_pkg::ST_GREAD;
                                end
                            end
                        end
                        gtr_pkg::OP_GLOAD:
                        begin
                            gl_we = 1'b1;
                        end
                        gtr_pkg::OP_FBREAD:
                        begin
                            iss_valid = 1'b1;
                            iss_read  = 1'b1;
                            iss_addr  = head.fb_addr;
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            gtr_pkg::ST_GREAD:
            begin
                col_next   = '0;
                state_next = gtr_pkg::ST_COLS;
            end
            gtr_pkg::ST_COLS:
            begin
                iss_valid = pl.hit && in_clip;
                iss_addr  = pl.addr;
                iss_bit   = pl.bit_idx;
                iss_value = gbits[shift[2:0]];
                if ({1'b0, col_reg} == cfg.glyph_width - 4'd1)
                begin
                    if (row_reg == gtr_pkg::ROW_W'(gtr_pkg::GLYPH_ROWS - 1))
                    begin
                        cursor_next = cursor_reg + 16'(cfg.glyph_width)
                                    + 16'(cfg.glyph_spacing);
                        state_next  = gtr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + 1'b1;
                        state_next = gtr_pkg::ST_GREAD;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = gtr_pkg::ST_IDLE;
            end
        endcase
    end

    // read-modify-write with a bypass from the write of the previous cycle
    always_comb
    begin
        s2_old  = (lw_valid_reg && (lw_addr_reg == s2_addr_reg)) ? lw_data_reg
                                                                 : fb_rd_data_reg;
        s2_mask = 8'h80 >> s2_bit_reg;
        s2_new  = s2_value_reg ? (s2_old | s2_mask) : (s2_old & ~s2_mask);
        if (clearing)
        begin
            fb_we = 1'b1;
            fb_wa = clr_cnt_reg;
            fb_wd = 8'h00;
        end
        else
        begin
            fb_we = s2_valid_reg && !s2_read_reg;
            fb_wa = s2_addr_reg;
            fb_wd = s2_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= gtr_pkg::ST_CLEAR;
            clr_cnt_reg  <= '0;
            cursor_reg   <= '0;
            s2_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clearing ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
            cursor_reg   <= cursor_next;
            s2_valid_reg <= iss_valid;
            lw_valid_reg <= fb_we && !clearing;
            done_reg     <= s2_valid_reg && s2_read_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg       <= row_next;
        col_reg       <= col_next;
        top_reg       <= top_next;
        clip_left_reg <= clip_left_next;
        clip_span_reg <= clip_span_next;
        base_reg      <= base_next;
        s2_read_reg   <= iss_read;
        s2_addr_reg   <= iss_addr;
        s2_bit_reg    <= iss_bit;
        s2_value_reg  <= iss_value;
        lw_addr_reg   <= fb_wa;
        lw_data_reg   <= fb_wd;
        if (s2_valid_reg && s2_read_reg)
        begin
            fb_byte_reg <= s2_old;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fb_we)
        begin
            fb_mem[fb_wa] <= fb_wd;
        end
        fb_rd_data_reg <= fb_mem[iss_addr];
    end

    always_ff @(posedge clk)
    begin
        if (gl_we)
        begin
            glyph_mem[head.glyph_addr] <= head.glyph_data;
        end
        if (state_reg == gtr_pkg::ST_GREAD)
        begin
            gl_rd_data_reg <= glyph_mem[gl_rd_addr[gtr_pkg::GL_AW-1:0]];
            gl_oob_reg     <= (gl_rd_addr >= 13'(gtr_pkg::FONT_BYTES));
        end
    end

endmodule

FILE: hdl/glyph_text_rasterizer.sv
// glyph_text_rasterizer: top level with configuration registers, front, command queue and back
// depends on gtr_pkg, gtr_front, gtr_cmd_queue and gtr_back
// read-back: a framebuffer read gives its byte on fb_byte with done once it has left the command
//   queue and passed the issue and merge stage registers; a new pixel, glyph load or read item
//   can follow while the last is still in the merge stage; a character does, for each of its
//   seven rows, one glyph row read then one pixel read-modify-write per column on the single framebuffer port
// reset: busy stays high while the framebuffer is cleared one byte a cycle;
//   done has no back-pressure, the receiver takes each result in its one cycle

module glyph_text_rasterizer (
    input  logic               clk,
    input  logic               rst_n,
    // command port
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         kind,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic               pixel_value,
    input  logic [7:0]         char_code,
    input  logic               start_text,
    input  logic signed [15:0] clip_left,
    input  logic [11:0]        clip_span,
    input  logic [9:0]         glyph_addr,
    input  logic [7:0]         glyph_data,
    input  logic [10:0]        fb_addr,
    // result port
    output logic [7:0]         fb_byte,
    output logic               done,
    // configuration write port
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [8:0]         cfg_data
);

    // raw register values as written
    logic [8:0]      fb_width_reg;
    logic [6:0]      fb_height_reg;
    logic [7:0]      first_code_reg;
    logic [7:0]      last_code_reg;
    logic [3:0]      glyph_width_reg;
    logic [2:0]      glyph_spacing_reg;
    logic [4:0]      glyph_bytes_reg;

    gtr_pkg::cfg_t   cfg;
    gtr_pkg::cmd_t   push_cmd;
    gtr_pkg::cmd_t   head;
    gtr_pkg::qstat_t qstat;
    logic            push;
    logic            pop;
    logic            clearing;

    // register writes, an index beyond the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_width_reg      <= 9'd128;
            fb_height_reg     <= 7'd32;
            first_code_reg    <= 8'd32;
            last_code_reg     <= 8'd126;
            glyph_width_reg   <= 4'd5;
            glyph_spacing_reg <= 3'd1;
            glyph_bytes_reg   <= 5'd7;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gtr_pkg::REG_FB_WIDTH:      fb_width_reg      <= cfg_data;
                gtr_pkg::REG_FB_HEIGHT:     fb_height_reg     <= cfg_data[6:0];
                gtr_pkg::REG_FIRST_CODE:    first_code_reg    <= cfg_data[7:0];
                gtr_pkg::REG_LAST_CODE:     last_code_reg     <= cfg_data[7:0];
                gtr_pkg::REG_GLYPH_WIDTH:   glyph_width_reg   <= cfg_data[3:0];
                gtr_pkg::REG_GLYPH_SPACING: glyph_spacing_reg <= cfg_data[2:0];
                gtr_pkg::REG_GLYPH_BYTES:   glyph_bytes_reg   <= cfg_data[4:0];
                default:
                begin
                    fb_width_reg <= fb_width_reg;
                end
            endcase
        end
    end

    // oversized display sizes clamp to what the framebuffer holds, glyph width to eight
    always_comb
    begin
        cfg.width         = (fb_width_reg > 9'(gtr_pkg::MAX_WIDTH))
                          ? 9'(gtr_pkg::MAX_WIDTH) : fb_width_reg;
        cfg.height        = (fb_height_reg > 7'(gtr_pkg::MAX_HEIGHT))
                          ? 7'(gtr_pkg::MAX_HEIGHT) : fb_height_reg;
        cfg.first_code    = first_code_reg;
        cfg.last_code     = last_code_reg;
        cfg.glyph_width   = (glyph_width_reg > 4'(gtr_pkg::MAX_GLYPH_W))
                          ? 4'(gtr_pkg::MAX_GLYPH_W) : glyph_width_reg;
        cfg.glyph_spacing = glyph_spacing_reg;
        cfg.glyph_bytes   = glyph_bytes_reg;
    end

    // front: transfer acceptance and command classification
    gtr_front u_front (
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pixel_value (pixel_value),
        .char_code   (char_code),
        .start_text  (start_text),
        .clip_left   (clip_left),
        .clip_span   (clip_span),
        .glyph_addr  (glyph_addr),
        .glyph_data  (glyph_data),
        .fb_addr     (fb_addr),
        .cfg         (cfg),
        .clearing    (clearing),
        .qstat       (qstat),
        .push        (push),
        .cmd         (push_cmd)
    );

    // two-entry queue decouples acceptance from drawing
    gtr_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    // back: framebuffer clear, pixel and character drawing, glyph loads, read-back
    gtr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .head     (head),
        .qstat    (qstat),
        .pop      (pop),
        .clearing (clearing),
        .fb_byte  (fb_byte),
        .done     (done)
    );

endmodule

FILE: tb/glyph_text_rasterizer_tb.sv
`timescale 1ns / 100ps
// glyph_text_rasterizer_tb: self-checking testbench for the glyph text rasterizer
// a directed table, then random pixel, character, glyph load and readback traffic over several
// register settings, each readback compared with the table byte or a local framebuffer model; depends on gtr_pkg

module glyph_text_rasterizer_tb;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 256;   // queue of two plus a character in the back
    localparam int PER_SETTING   = 133;
    localparam int NUM_SETTINGS  = 7;
    localparam int DIRECTED_ROWS = 25;

    // one command as it goes onto the command port
    typedef struct packed {
        gtr_pkg::op_t       kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic               pixel_value;
        logic [7:0]         char_code;
        logic               start_text;
        logic signed [15:0] clip_left;
        logic [11:0]        clip_span;
        logic [9:0]         glyph_addr;
        logic [7:0]         glyph_data;
        logic [10:0]        fb_addr;
    } cmd_item_t;

    // directed row: a command and, where obvious, the byte it must read back
    typedef struct {
        cmd_item_t  cmd;
        bit         typed;
        logic [7:0] byte_val;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               pixel_value;
    logic [7:0]         char_code;
    logic               start_text;
    logic signed [15:0] clip_left;
    logic [11:0]        clip_span;
    logic [9:0]         glyph_addr;
    logic [7:0]         glyph_data;
    logic [10:0]        fb_addr;
    logic [7:0]         fb_byte;
    logic               done;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [8:0]         cfg_data;

    glyph_text_rasterizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pixel_value (pixel_value),
        .char_code   (char_code),
        .start_text  (start_text),
        .clip_left   (clip_left),
        .clip_span   (clip_span),
        .glyph_addr  (glyph_addr),
        .glyph_data  (glyph_data),
        .fb_addr     (fb_addr),
        .fb_byte     (fb_byte),
        .done        (done),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // local copy of the block: framebuffer, font, cursor and registers
    logic [7:0]  frame_model [gtr_pkg::FB_BYTES];
    logic [7:0]  glyph_model [gtr_pkg::FONT_BYTES];
    bit          glyph_loaded [gtr_pkg::FONT_BYTES];
    logic [15:0] cursor_model;
    logic [8:0]  m_width;
    logic [6:0]  m_height;
    logic [7:0]  m_first;
    logic [7:0]  m_last;
    logic [3:0]  m_gw;
    logic [2:0]  m_gspacing;
    logic [4:0]  m_gbytes;

    logic [7:0] readback_q [$];     // bytes still owed by outstanding framebuffer reads
    int         mismatch_count = 0;
    int         items_sent;
    int         idle_pct;
    int         cycle_count = 0;

    dir_row_t dir_tab [DIRECTED_ROWS];

    // register settings, one row per phase, columns in register index order
    logic [8:0] reg_sets [NUM_SETTINGS][7] = '{
        '{9'd256, 9'd64,  9'd0,   9'd255, 9'd8,  9'd7, 9'd16},  // largest legal sizes, full font
        '{9'd1,   9'd1,   9'd255, 9'd255, 9'd1,  9'd0, 9'd7},   // one pixel display, one code
        '{9'd77,  9'd13,  9'd65,  9'd90,  9'd3,  9'd2, 9'd9},   // odd width, partial last byte
        '{9'd511, 9'd127, 9'd10,  9'd40,  9'd15, 9'd3, 9'd31},  // oversized, saturates
        '{9'd0,   9'd64,  9'd0,   9'd127, 9'd0,  9'd5, 9'd0},   // zero width, spacing-only advance
        '{9'd200, 9'd40,  9'd32,  9'd126, 9'd7,  9'd1, 9'd12},
        '{9'd160, 9'd48,  9'd200, 9'd100, 9'd9,  9'd7, 9'd1}    // empty font range
    };

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // saturated sizes as the datapath uses them
    function automatic int disp_w();
        return (m_width > gtr_pkg::MAX_WIDTH) ? gtr_pkg::MAX_WIDTH : int'(m_width);
    endfunction

    function automatic int disp_h();
        return (m_height > gtr_pkg::MAX_HEIGHT) ? gtr_pkg::MAX_HEIGHT : int'(m_height);
    endfunction

    function automatic int font_gw();
        return (m_gw > gtr_pkg::MAX_GLYPH_W) ? gtr_pkg::MAX_GLYPH_W : int'(m_gw);
    endfunction

    // bounds check, mirrored x, msb-first bit within the row byte
    function automatic void plot_pixel(input int x, input int y, input logic on);
        int w;
        int h;
        int mx;
        int off;
        w = disp_w();
        h = disp_h();
        if (x < 0 || x >= w || y < 0 || y >= h)
            return;
        mx  = w - 1 - x;
        off = y * ((w + 7) / 8) + (mx >> 3);
        if (off < gtr_pkg::FB_BYTES)
            frame_model[off][7 - (mx & 7)] = on;
    endfunction

    // applies one transferred command to the model; gives the byte a read returns
    task automatic rasterize_cmd(input cmd_item_t c, output bit gives, output logic [7:0] rd);
        int         gw;
        int         cx;
        int         cl;
        int         span;
        int         base;
        int         a;
        int         px;
        int         code;
        logic [7:0] bits;
        gives = 1'b0;
        rd    = 8'h00;
        case (c.kind)
            gtr_pkg::OP_PIXEL:
                plot_pixel(int'($signed(c.pos_x)), int'($signed(c.pos_y)), c.pixel_value);
            gtr_pkg::OP_CHAR:
            begin
                // cursor loads even for a code outside the font
                if (c.start_text)
                    cursor_model = c.pos_x;
                code = int'(c.char_code);
                if (code >= int'(m_first) && code <= int'(m_last))
                begin
                    gw   = font_gw();
                    cx   = int'($signed(cursor_model));
                    cl   = int'($signed(c.clip_left));
                    span = int'(c.clip_span);
                    base = int'(m_gbytes) * (code - int'(m_first));
                    for (int row = 0; row < gtr_pkg::GLYPH_ROWS; row++)
                    begin
                        a    = base + row;
                        // rows past the end of the font read as blank
                        bits = (a < gtr_pkg::FONT_BYTES) ? glyph_model[a] : 8'h00;
                        for (int col = 0; col < gw; col++)
                        begin
                            px = cx + col;
                            if (span == 0 || (px >= cl && px < cl + span))
                                plot_pixel(px, int'($signed(c.pos_y)) + row, bits[gw - 1 - col]);
                        end
                    end
                    cursor_model = cursor_model + 16'(gw + int'(m_gspacing));
                end
            end
            gtr_pkg::OP_GLOAD:
            begin
                glyph_model[c.glyph_addr]  = c.glyph_data;
                glyph_loaded[c.glyph_addr] = 1'b1;
            end
            default:
            begin
                gives = 1'b1;
                rd    = frame_model[c.fb_addr];
            end
        endcase
    endtask

    // every field but the kind random, so fields a command does not use still toggle
    function automatic cmd_item_t noise_cmd();
        cmd_item_t c;
        c.kind        = gtr_pkg::OP_PIXEL;
        c.pos_x       = 16'($urandom);
        c.pos_y       = 16'($urandom);
        c.pixel_value = 1'($urandom);
        c.char_code   = 8'($urandom);
        c.start_text  = 1'($urandom);
        c.clip_left   = 16'($urandom);
        c.clip_span   = 12'($urandom);
        c.glyph_addr  = 10'($urandom);
        c.glyph_data  = 8'($urandom);
        c.fb_addr     = 11'($urandom);
        return c;
    endfunction

    function automatic cmd_item_t pixel_cmd(input logic signed [15:0] x,
                                            input logic signed [15:0] y, input logic v);
        cmd_item_t c;
        c             = noise_cmd();
        c.kind        = gtr_pkg::OP_PIXEL;
        c.pos_x       = x;
        c.pos_y       = y;
        c.pixel_value = v;
        return c;
    endfunction

    function automatic cmd_item_t char_cmd(input logic [7:0] code, input logic st,
                                           input logic signed [15:0] x,
                                           input logic signed [15:0] y,
                                           input logic signed [15:0] cl,
                                           input logic [11:0] cs);
        cmd_item_t c;
        c            = noise_cmd();
        c.kind       = gtr_pkg::OP_CHAR;
        c.char_code  = code;
        c.start_text = st;
        c.pos_x      = x;
        c.pos_y      = y;
        c.clip_left  = cl;
        c.clip_span  = cs;
        return c;
    endfunction

    function automatic cmd_item_t load_cmd(input logic [9:0] a, input logic [7:0] d);
        cmd_item_t c;
        c            = noise_cmd();
        c.kind       = gtr_pkg::OP_GLOAD;
        c.glyph_addr = a;
        c.glyph_data = d;
        return c;
    endfunction

    function automatic cmd_item_t read_cmd(input logic [10:0] a);
        cmd_item_t c;
        c         = noise_cmd();
        c.kind    = gtr_pkg::OP_FBREAD;
        c.fb_addr = a;
        return c;
    endfunction

    // coordinate mostly around the display, sometimes at the 16-bit extremes
    function automatic logic signed [15:0] rand_coord(input int extent);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return 16'($urandom);
        if (pick < 14)
            return 16'(32767 - int'($urandom_range(0, 15)));
        if (pick < 18)
            return 16'(-32768 + int'($urandom_range(0, 15)));
        return 16'(int'($urandom_range(0, extent + 16)) - 8);
    endfunction

    // one command transfer: optional idle gap, then hold start until busy is low at an edge
    task automatic issue_cmd(input cmd_item_t c, input bit typed, input logic [7:0] typed_byte);
        int         gap;
        bit         gives;
        logic [7:0] rd;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        kind        <= c.kind;
        pos_x       <= c.pos_x;
        pos_y       <= c.pos_y;
        pixel_value <= c.pixel_value;
        char_code   <= c.char_code;
        start_text  <= c.start_text;
        clip_left   <= c.clip_left;
        clip_span   <= c.clip_span;
        glyph_addr  <= c.glyph_addr;
        glyph_data  <= c.glyph_data;
        fb_addr     <= c.fb_addr;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        // transfer taken at this edge
        rasterize_cmd(c, gives, rd);
        if (gives)
            readback_q.push_back(typed ? typed_byte : rd);
        items_sent++;
    endtask

    // block idle: nothing owed, busy low, and time for queued characters to finish
    task automatic settle();
        start <= 1'b0;
        while (readback_q.size() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // readback checker, done has no back-pressure so every strobe is a result
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (readback_q.size() == 0)
                report_mismatch($sformatf("fb_byte %02h with no read outstanding", fb_byte));
            else if (fb_byte !== readback_q[0])
                report_mismatch($sformatf("fb_byte got %02h, expected %02h",
                                          fb_byte, readback_q[0]));
            if (readback_q.size() != 0)
                void'(readback_q.pop_front());
        end
    end

    initial
    begin
        int                 pick;
        int                 code;
        int                 base;
        int                 a;
        int                 rb;
        int                 target;
        logic               st;
        logic signed [15:0] xpos;
        logic signed [15:0] anchor;
        logic signed [15:0] cl;
        logic [11:0]        cs;
        logic [8:0]         keep;
        gtr_pkg::reg_idx_t  ri;

        // every input known from time zero
        rst_n       <= 1'b0;
        start       <= 1'b0;
        kind        <= gtr_pkg::OP_PIXEL;
        pos_x       <= '0;
        pos_y       <= '0;
        pixel_value <= 1'b0;
        char_code   <= '0;
        start_text  <= 1'b0;
        clip_left   <= '0;
        clip_span   <= '0;
        glyph_addr  <= '0;
        glyph_data  <= '0;
        fb_addr     <= '0;
        cfg_we      <= 1'b0;
        cfg_index   <= gtr_pkg::REG_FB_WIDTH;
        cfg_data    <= '0;
        items_sent     = 0;

        // model after reset: cleared framebuffer, cursor zero, default registers
        foreach (frame_model[i])
            frame_model[i] = 8'h00;
        cursor_model = '0;
        m_width      = 9'd128;
        m_height     = 7'd32;
        m_first      = 8'd32;
        m_last       = 8'd126;
        m_gw         = 4'd5;
        m_gspacing   = 3'd1;
        m_gbytes     = 5'd7;

        // directed table at reset settings: 16 bytes per row, code 32 at glyph address 0
        dir_tab[0]  = '{read_cmd(11'd0), 1'b1, 8'h00};          // cleared after reset
        dir_tab[1]  = '{read_cmd(11'd2047), 1'b1, 8'h00};
        dir_tab[2]  = '{pixel_cmd(16'sd0, 16'sd0, 1'b1), 1'b0, 8'h00};
        dir_tab[3]  = '{read_cmd(11'd15), 1'b1, 8'h01};         // x 0 mirrors to last byte, lsb
        dir_tab[4]  = '{pixel_cmd(16'sd127, 16'sd31, 1'b1), 1'b0, 8'h00};
        dir_tab[5]  = '{read_cmd(11'd496), 1'b1, 8'h80};        // last pixel lands at row start, msb
        dir_tab[6]  = '{pixel_cmd(16'sd128, 16'sd0, 1'b1), 1'b0, 8'h00};
        dir_tab[7]  = '{pixel_cmd(16'sd0, 16'sd32, 1'b1), 1'b0, 8'h00};
        dir_tab[8]  = '{pixel_cmd(16'sh8000, 16'sh7FFF, 1'b1), 1'b0, 8'h00};
        dir_tab[9]  = '{pixel_cmd(16'sd0, 16'sd0, 1'b0), 1'b0, 8'h00};
        dir_tab[10] = '{read_cmd(11'd15), 1'b1, 8'h00};         // cleared again
        dir_tab[11] = '{load_cmd(10'd0, 8'hFF), 1'b0, 8'h00};
        dir_tab[12] = '{load_cmd(10'd1, 8'h00), 1'b0, 8'h00};
        dir_tab[13] = '{load_cmd(10'd2, 8'h11), 1'b0, 8'h00};
        dir_tab[14] = '{load_cmd(10'd3, 8'h0A), 1'b0, 8'h00};
        dir_tab[15] = '{load_cmd(10'd4, 8'h1F), 1'b0, 8'h00};
        dir_tab[16] = '{load_cmd(10'd5, 8'h15), 1'b0, 8'h00};
        dir_tab[17] = '{load_cmd(10'd6, 8'h04), 1'b0, 8'h00};
        dir_tab[18] = '{load_cmd(10'd1023, 8'hA5), 1'b0, 8'h00};
        dir_tab[19] = '{char_cmd(8'd32, 1'b1, 16'sd0, 16'sd0, 16'sd0, 12'd0), 1'b0, 8'h00};
        // above the font: cursor loads, nothing drawn, no advance
        dir_tab[20] = '{char_cmd(8'd127, 1'b1, 16'sd100, 16'sd0, 16'sd0, 12'd0), 1'b0, 8'h00};
        // below the font, cursor untouched
        dir_tab[21] = '{char_cmd(8'd31, 1'b0, 16'sh7FFF, 16'sd0, 16'sd0, 12'd0), 1'b0, 8'h00};
        // partly above the top edge, clipped to two columns
        dir_tab[22] = '{char_cmd(8'd32, 1'b0, 16'sd0, -16'sd3, 16'sd102, 12'd2), 1'b0, 8'h00};
        dir_tab[23] = '{read_cmd(11'd15), 1'b0, 8'h00};
        dir_tab[24] = '{read_cmd(11'd3), 1'b0, 8'h00};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // first transfer waits out the framebuffer clearing pass
        idle_pct = 30;
        foreach (dir_tab[i])
            issue_cmd(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].byte_val);

        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            settle();

            // write every register; bits above a register's width are noise
            ri = ri.first();
            do
            begin
                case (ri)
                    gtr_pkg::REG_FB_WIDTH:
                    begin
                        keep    = 9'h1FF;
                        m_width = reg_sets[s][ri];
                    end
                    gtr_pkg::REG_FB_HEIGHT:
                    begin
                        keep     = 9'h07F;
                        m_height = reg_sets[s][ri][6:0];
                    end
                    gtr_pkg::REG_FIRST_CODE:
                    begin
                        keep    = 9'h0FF;
                        m_first = reg_sets[s][ri][7:0];
                    end
                    gtr_pkg::REG_LAST_CODE:
                    begin
                        keep   = 9'h0FF;
                        m_last = reg_sets[s][ri][7:0];
                    end
                    gtr_pkg::REG_GLYPH_WIDTH:
                    begin
                        keep = 9'h00F;
                        m_gw = reg_sets[s][ri][3:0];
                    end
                    gtr_pkg::REG_GLYPH_SPACING:
                    begin
                        keep       = 9'h007;
                        m_gspacing = reg_sets[s][ri][2:0];
                    end
                    default:
                    begin
                        keep     = 9'h01F;
                        m_gbytes = reg_sets[s][ri][4:0];
                    end
                endcase
                cfg_we    <= 1'b1;
                cfg_index <= ri;
                cfg_data  <= reg_sets[s][ri] | (9'($urandom) & ~keep);
                @(posedge clk);
                ri = ri.next();
            end
            while (ri != ri.first());
            cfg_we <= 1'b0;

            // sender idles 30 percent, then 70, then not at all
            idle_pct = (s < 2) ? 30 : (s < 4) ? 70 : 0;

            target = items_sent + PER_SETTING;
            while (items_sent < target)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                begin
                    issue_cmd(pixel_cmd(rand_coord(disp_w()), rand_coord(disp_h()),
                                        1'($urandom)), 1'b0, 8'h00);
                end
                else if (pick < 65)
                begin
                    // mostly codes inside the font, the rest anywhere
                    if (m_first <= m_last && $urandom_range(0, 99) < 85)
                        code = $urandom_range(m_first, m_last);
                    else
                        code = $urandom_range(0, 255);
                    // load any glyph row this character would read that was never written
                    if (code >= int'(m_first) && code <= int'(m_last))
                    begin
                        base = int'(m_gbytes) * (code - int'(m_first));
                        for (int row = 0; row < gtr_pkg::GLYPH_ROWS; row++)
                        begin
                            a = base + row;
                            if (a < gtr_pkg::FONT_BYTES && !glyph_loaded[a])
                                issue_cmd(load_cmd(10'(a), 8'($urandom)), 1'b0, 8'h00);
                        end
                    end
                    st     = ($urandom_range(0, 99) < 30);
                    xpos   = rand_coord(disp_w());
                    anchor = st ? xpos : $signed(cursor_model);
                    pick   = $urandom_range(0, 99);
                    if (pick < 50)
                    begin
                        cl = 16'($urandom);
                        cs = 12'd0;
                    end
                    else if (pick < 85)
                    begin
                        // narrow window around where the character lands
                        cl = 16'(int'(anchor) + int'($urandom_range(0, 12)) - 4);
                        cs = 12'($urandom_range(1, 10));
                    end
                    else
                    begin
                        cl = 16'($urandom);
                        cs = 12'($urandom);
                    end
                    issue_cmd(char_cmd(8'(code), st, xpos, rand_coord(disp_h()), cl, cs),
                              1'b0, 8'h00);
                end
                else if (pick < 75)
                begin
                    issue_cmd(load_cmd(10'($urandom), 8'($urandom)), 1'b0, 8'h00);
                end
                else
                begin
                    // mostly bytes inside the visible area
                    if (disp_w() > 0 && disp_h() > 0 && $urandom_range(0, 99) < 60)
                    begin
                        rb = (disp_w() + 7) / 8;
                        a  = int'($urandom_range(0, disp_h() - 1)) * rb
                           + int'($urandom_range(0, rb - 1));
                    end
                    else
                    begin
                        a = $urandom_range(0, gtr_pkg::FB_BYTES - 1);
                    end
                    issue_cmd(read_cmd(11'(a)), 1'b0, 8'h00);
                end
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
hdl/gtr_pkg.sv
hdl/gtr_front.sv
hdl/gtr_cmd_queue.sv
hdl/gtr_back.sv
hdl/glyph_text_rasterizer.sv
tb/glyph_text_rasterizer_tb.sv
